FILE: sv/anbsplit_pkg.sv
// ----------------------------------------------------------------------------
// anbsplit_pkg
// Shared types and constants of the Annex B NAL unit splitter: the command
// that travels from the byte classifier to the result expander.
// ----------------------------------------------------------------------------
package anbsplit_pkg;

   localparam int BYTE_W      = 8;
   localparam int TYPE_W      = 5;
   localparam int OUT_INDEX_W = 16;
   localparam int ZERO_CMD_W  = 3;   // up to four zeros released by one byte
   localparam int STEP_W      = 3;   // up to five micro-operations per command

   localparam logic [BYTE_W-1:0] ZERO_BYTE = 8'h00;
   localparam logic [BYTE_W-1:0] ONE_BYTE  = 8'h01;
   localparam logic [BYTE_W-1:0] TYPE_MASK = 8'h1f;
   localparam logic [TYPE_W-1:0] IDR_TYPE  = 5'd5;
   localparam logic [1:0]        ZERO_HOLD_MAX = 2'd3;
   localparam logic [1:0]        START_ZEROS   = 2'd2;

   // Work for the back end: push some zeros, then maybe a byte, then maybe
   // close the open unit.
   typedef struct packed {
      logic [ZERO_CMD_W-1:0] zeros;
      logic                  push_byte;
      logic [BYTE_W-1:0]     data;
      logic                  close;
   } cmd_type;

endpackage

FILE: sv/anbsplit_front.sv
// ----------------------------------------------------------------------------
// anbsplit_front
// Byte classifier: tracks start code zeros and whether a unit is open, and
// turns each accepted byte into a command for the result expander.
// ----------------------------------------------------------------------------
module anbsplit_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [anbsplit_pkg::BYTE_W-1:0] req_in_byte,
   input  logic                          req_buffer_end,
   input  logic                          queue_full,
   output logic                          cmd_push,
   output anbsplit_pkg::cmd_type         cmd_data
);
   import anbsplit_pkg::*;

   logic       inside_ff, inside_in;
   logic [1:0] held_ff, held_in;
   logic       accept;
   cmd_type    cmd;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // Classify the byte and build its command
   always_comb begin
      inside_in     = inside_ff;
      held_in       = held_ff;
      cmd.zeros     = '0;
      cmd.push_byte = 1'b0;
      cmd.data      = req_in_byte;
      cmd.close     = 1'b0;
      if (req_in_byte == ZERO_BYTE) begin
         if (held_ff != ZERO_HOLD_MAX) begin
            held_in = held_ff + 2'd1;
         end else if (inside_ff) begin
            cmd.zeros = ZERO_CMD_W'(1);
         end
      end else if (req_in_byte == ONE_BYTE && held_ff >= START_ZEROS) begin
         cmd.close = inside_ff;
         held_in   = '0;
         inside_in = 1'b1;
      end else begin
         if (inside_ff) begin
            cmd.zeros     = ZERO_CMD_W'(held_ff);
            cmd.push_byte = 1'b1;
         end
         held_in = '0;
      end
      // Buffer end flushes held zeros and closes the unit
      if (req_buffer_end) begin
         if (inside_in) begin
            cmd.zeros = cmd.zeros + ZERO_CMD_W'(held_in);
            cmd.close = 1'b1;
         end
         inside_in = 1'b0;
         held_in   = '0;
      end
   end

   // Drop commands that carry no work
   assign cmd_push = accept && (cmd.zeros != '0 || cmd.push_byte || cmd.close);
   assign cmd_data = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         held_ff   <= '0;
      end else if (accept) begin
         inside_ff <= inside_in;
         held_ff   <= held_in;
      end
   end

endmodule

FILE: sv/anbsplit_queue.sv
// ----------------------------------------------------------------------------
// anbsplit_queue
// Short command queue between the classifier and the expander.
// ----------------------------------------------------------------------------
module anbsplit_queue #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  anbsplit_pkg::cmd_type push_data,
   output logic                  full,
   input  logic                  pop,
   output anbsplit_pkg::cmd_type head,
   output logic                  head_valid
);
   import anbsplit_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   cmd_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_push, do_pop;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   // Store the incoming transaction
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: sv/anbsplit_back.sv
// ----------------------------------------------------------------------------
// anbsplit_back
// Result expander: steps through each command one micro-operation a cycle
// if not stalled, keeps the pending payload byte, drives the output register.
// ----------------------------------------------------------------------------
module anbsplit_back #(
   parameter int INDEX_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  anbsplit_pkg::cmd_type               head,
   input  logic                                head_valid,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [anbsplit_pkg::BYTE_W-1:0]     rsp_out_byte,
   output logic                                rsp_nal_first,
   output logic                                rsp_nal_last,
   output logic [anbsplit_pkg::TYPE_W-1:0]     rsp_unit_type,
   output logic                                rsp_idr_flag,
   output logic [anbsplit_pkg::OUT_INDEX_W-1:0] rsp_byte_index,
   output logic                                rsp_step_last
);
   import anbsplit_pkg::*;

   logic [STEP_W-1:0]     step_ff, step_in;
   logic [STEP_W-1:0]     n_ops;
   logic                  is_zero, is_byte, is_close, is_final;
   logic                  out_free, fire, emit;
   logic [BYTE_W-1:0]     push_val, push_masked;

   // pending payload byte
   logic                  pend_valid_ff;
   logic [BYTE_W-1:0]     pend_value_ff;
   logic                  pend_first_ff;
   logic [TYPE_W-1:0]     cur_type_ff;
   logic [INDEX_BITS-1:0] count_ff;
   logic [31:0]           count_wide;

   // output register
   logic                   rsp_valid_ff;
   logic [BYTE_W-1:0]      out_byte_ff;
   logic                   first_ff, last_ff, idr_ff, step_last_ff;
   logic [TYPE_W-1:0]      type_ff;
   logic [OUT_INDEX_W-1:0] index_ff;

   // Decode the current micro-operation of the head command
   assign n_ops    = STEP_W'(head.zeros) + STEP_W'(head.push_byte) + STEP_W'(head.close);
   assign is_zero  = (STEP_W'(head.zeros) > step_ff);
   assign is_byte  = !is_zero && head.push_byte && (step_ff == STEP_W'(head.zeros));
   assign is_close = !is_zero && !is_byte;
   assign is_final = (step_ff == n_ops - STEP_W'(1));

   // Every operation emits the pending byte, if there is one
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign fire     = head_valid && (!pend_valid_ff || out_free);
   assign emit     = fire && pend_valid_ff;
   assign pop      = fire && is_final;
   assign step_in  = pop ? '0 : step_ff + STEP_W'(1);

   assign push_val    = is_byte ? head.data : ZERO_BYTE;
   assign push_masked = push_val & TYPE_MASK;
   assign count_wide  = 32'(count_ff);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= '0;
         pend_valid_ff <= 1'b0;
         pend_first_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (fire) begin
            step_ff       <= step_in;
            pend_valid_ff <= !is_close;
            pend_first_ff <= !is_close && !pend_valid_ff;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Pending byte payload, unit type and saturating index
   always_ff @(posedge clock) begin
      if (fire) begin
         if (is_close) begin
            count_ff <= '0;
         end else begin
            pend_value_ff <= push_val;
            if (pend_valid_ff) begin
               if (!(&count_ff)) begin
                  count_ff <= count_ff + INDEX_BITS'(1);
               end
            end else begin
               count_ff    <= '0;
               cur_type_ff <= push_masked[TYPE_W-1:0];
            end
         end
      end
   end

   // Load the output register with the pending byte
   always_ff @(posedge clock) begin
      if (emit) begin
         out_byte_ff  <= pend_value_ff;
         first_ff     <= pend_first_ff;
         last_ff      <= is_close;
         type_ff      <= cur_type_ff;
         idr_ff       <= (cur_type_ff == IDR_TYPE);
         index_ff     <= count_wide[OUT_INDEX_W-1:0];
         step_last_ff <= is_final;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_nal_first  = first_ff;
   assign rsp_nal_last   = last_ff;
   assign rsp_unit_type  = type_ff;
   assign rsp_idr_flag   = idr_ff;
   assign rsp_byte_index = index_ff;
   assign rsp_step_last  = step_last_ff;

endmodule

FILE: sv/annexb_nal_unit_splitter.sv
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter
// Annex B start code parser: strips start codes and tags NAL payload bytes.
// ----------------------------------------------------------------------------
// One input byte is taken per cycle while the command queue has room. Each
// byte becomes a command in the classifier; the expander then works through
// it one micro-operation at a time, so an ordinary payload byte needs one
// micro-operation and a byte that releases held zeros or ends a buffer needs
// up to five, producing up to five results. The queue (QUEUE_DEPTH commands)
// soaks up these bursts; req_stall rises only when it is full. A result
// passes through the command queue and the output register after the byte
// that completes it, every payload byte being held back until the next one
// arrives or its unit closes, so the last can be marked.
// ----------------------------------------------------------------------------
module annexb_nal_unit_splitter #(
   parameter int INDEX_BITS  = 16,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [anbsplit_pkg::BYTE_W-1:0]      req_in_byte,
   input  logic                                 req_buffer_end,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [anbsplit_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic                                 rsp_nal_first,
   output logic                                 rsp_nal_last,
   output logic [anbsplit_pkg::TYPE_W-1:0]      rsp_unit_type,
   output logic                                 rsp_idr_flag,
   output logic [anbsplit_pkg::OUT_INDEX_W-1:0] rsp_byte_index,
   output logic                                 rsp_step_last
);
   import anbsplit_pkg::*;

   logic    queue_full, cmd_push, pop, head_valid;
   cmd_type cmd_data, head;

   // Classify incoming bytes
   anbsplit_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .req_buffer_end (req_buffer_end),
      .queue_full     (queue_full),
      .cmd_push       (cmd_push),
      .cmd_data       (cmd_data)
   );

   // Decouple classifier and expander
   anbsplit_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_data  (cmd_data),
      .full       (queue_full),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid)
   );

   // Expand commands into results
   anbsplit_back #(
      .INDEX_BITS (INDEX_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .head_valid     (head_valid),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_nal_first  (rsp_nal_first),
      .rsp_nal_last   (rsp_nal_last),
      .rsp_unit_type  (rsp_unit_type),
      .rsp_idr_flag   (rsp_idr_flag),
      .rsp_byte_index (rsp_byte_index),
      .rsp_step_last  (rsp_step_last)
   );

endmodule

FILE: sv/anbsplit_checker.sv
// ----------------------------------------------------------------------------
// anbsplit_checker
// Port-level checks of the NAL unit splitter, bound to the top level.
// ----------------------------------------------------------------------------
module anbsplit_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic [anbsplit_pkg::BYTE_W-1:0]      req_in_byte,
   input logic                                 req_buffer_end,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [anbsplit_pkg::BYTE_W-1:0]      rsp_out_byte,
   input logic                                 rsp_nal_first,
   input logic                                 rsp_nal_last,
   input logic [anbsplit_pkg::TYPE_W-1:0]      rsp_unit_type,
   input logic                                 rsp_idr_flag,
   input logic [anbsplit_pkg::OUT_INDEX_W-1:0] rsp_byte_index,
   input logic                                 rsp_step_last
);
   import anbsplit_pkg::*;

   // No result straight after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result transaction holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_byte_index) && $stable(rsp_nal_last))
      else $error("stalled result changed");

   // Header byte starts at index zero and carries its own type
   a_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_nal_first |-> rsp_byte_index == '0
         && rsp_unit_type == rsp_out_byte[TYPE_W-1:0])
      else $error("header byte mismatch");

   // IDR marker follows the unit type
   a_idr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_idr_flag == (rsp_unit_type == IDR_TYPE))
      else $error("idr flag mismatch");

   // Type stays constant between consecutive results of one unit
   a_type_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_nal_last ##1 rsp_valid && !rsp_nal_first
         |-> rsp_unit_type == $past(rsp_unit_type))
      else $error("unit type changed within unit");

endmodule

bind annexb_nal_unit_splitter anbsplit_checker u_anbsplit_checker (.*);

FILE: tb/annexb_nal_unit_splitter_tb.sv
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter_tb
// Self-checking bench for the Annex B start code parser.
// ----------------------------------------------------------------------------
// A driver feeds stream bytes from a queue. An in-bench parser predicts the
// tagged NAL payload bytes that each accepted byte causes. A monitor compares
// every result transaction against the oldest prediction. The stimulus opens
// with a hand-built stream, then runs well-formed buffers mixed with noise
// under several idling mixes. It ends with a long output hold-off while bytes
// keep arriving.
// ----------------------------------------------------------------------------
module annexb_nal_unit_splitter_tb;
   import anbsplit_pkg::*;

   localparam int INDEX_BITS      = 16;
   localparam longint unsigned INDEX_MAX = (64'd1 << INDEX_BITS) - 1;
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int DRAIN_CYCLES    = 16;
   localparam int HOLD_CYCLES     = 300;
   localparam int PHASE_BYTES     = 80;
   localparam int HOLD_BYTES      = 40;

   // Opening stream: junk before the first start code, a lone 00 01 outside a
   // unit, a 3-byte start code, an IDR header, zeros released by a non-start
   // byte, a 4-byte start code closing the unit, empty units, and a buffer
   // end landing on three held zeros.
   localparam logic [0:24][BYTE_W-1:0] OPENING_BYTES = {
      8'h55, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'h65, 8'hff, 8'h00, 8'h00,
      8'h03, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00,
      8'h01, 8'h80, 8'h00, 8'h00, 8'h00};

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              buf_end;
   } stream_byte_type;

   typedef struct packed {
      logic [BYTE_W-1:0]      data;
      logic                   first;
      logic                   last;
      logic [TYPE_W-1:0]      kind;
      logic                   idr;
      logic [OUT_INDEX_W-1:0] index;
      logic                   step_last;
   } nal_byte_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [BYTE_W-1:0]      req_in_byte = '0;
   logic                   req_buffer_end = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [BYTE_W-1:0]      rsp_out_byte;
   logic                   rsp_nal_first;
   logic                   rsp_nal_last;
   logic [TYPE_W-1:0]      rsp_unit_type;
   logic                   rsp_idr_flag;
   logic [OUT_INDEX_W-1:0] rsp_byte_index;
   logic                   rsp_step_last;

   // Parser state of the prediction
   bit                in_unit;
   logic [1:0]        zero_run;
   bit                held_valid;
   logic [BYTE_W-1:0] held_byte;
   bit                held_is_first;
   logic [TYPE_W-1:0] unit_kind;
   longint unsigned   unit_pos;

   nal_byte_type    step_bytes[$];
   nal_byte_type    expected_nal_bytes[$];
   stream_byte_type stream_q[$];
   stream_byte_type drive_byte;
   nal_byte_type    want_byte;

   int          idle_pct = 0;
   int          stall_pct = 0;
   bit          hold_request = 1'b0;
   int          hold_left = 0;
   int unsigned cycle_count = 0;
   int unsigned failures = 0;
   int unsigned bytes_accepted = 0;
   int unsigned nal_bytes_checked = 0;
   int unsigned units_seen = 0;

   annexb_nal_unit_splitter #(
      .INDEX_BITS(INDEX_BITS)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_byte   (req_in_byte),
      .req_buffer_end(req_buffer_end),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_nal_first (rsp_nal_first),
      .rsp_nal_last  (rsp_nal_last),
      .rsp_unit_type (rsp_unit_type),
      .rsp_idr_flag  (rsp_idr_flag),
      .rsp_byte_index(rsp_byte_index),
      .rsp_step_last (rsp_step_last)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------
   function automatic void clear_parser();
      in_unit       = 1'b0;
      zero_run      = '0;
      held_valid    = 1'b0;
      held_byte     = '0;
      held_is_first = 1'b0;
      unit_kind     = '0;
      unit_pos      = 0;
   endfunction

   function automatic void emit_held(bit last);
      nal_byte_type nb;
      nb.data      = held_byte;
      nb.first     = held_is_first;
      nb.last      = last;
      nb.kind      = unit_kind;
      nb.idr       = (unit_kind == IDR_TYPE);
      nb.index     = unit_pos[OUT_INDEX_W-1:0];
      nb.step_last = 1'b0;
      step_bytes.push_back(nb);
   endfunction

   // Move a payload byte into the held stage, letting the previous one out
   function automatic void shift_in(logic [BYTE_W-1:0] b);
      if (held_valid) begin
         emit_held(1'b0);
         if (unit_pos < INDEX_MAX) unit_pos++;
         held_is_first = 1'b0;
      end else begin
         unit_pos      = 0;
         held_is_first = 1'b1;
         unit_kind     = TYPE_W'(b & TYPE_MASK);
      end
      held_byte  = b;
      held_valid = 1'b1;
   endfunction

   function automatic void flush_zeros();
      while (zero_run != 0) begin
         shift_in(ZERO_BYTE);
         zero_run--;
      end
   endfunction

   function automatic void close_held();
      if (held_valid) emit_held(1'b1);
      held_valid    = 1'b0;
      held_is_first = 1'b0;
      unit_pos      = 0;
   endfunction

   function automatic void parse_byte(logic [BYTE_W-1:0] b, logic buf_end);
      step_bytes.delete();
      if (b == ZERO_BYTE) begin
         // hold up to three zeros, a further one is payload
         if (zero_run < ZERO_HOLD_MAX) zero_run++;
         else if (in_unit) shift_in(ZERO_BYTE);
      end else if (b == ONE_BYTE && zero_run >= START_ZEROS) begin
         // start code: close the open unit, drop the zeros
         if (in_unit) close_held();
         zero_run = '0;
         in_unit  = 1'b1;
         unit_pos = 0;
      end else begin
         if (in_unit) begin
            flush_zeros();
            shift_in(b);
         end
         zero_run = '0;
      end
      if (buf_end) begin
         if (in_unit) begin
            flush_zeros();
            close_held();
         end
         clear_parser();
      end
      if (step_bytes.size() != 0) step_bytes[step_bytes.size()-1].step_last = 1'b1;
      foreach (step_bytes[i]) expected_nal_bytes.push_back(step_bytes[i]);
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus generation
   // ------------------------------------------------------------------------
   function automatic void push_stream(logic [BYTE_W-1:0] b, logic buf_end);
      stream_byte_type sb;
      sb.data    = b;
      sb.buf_end = buf_end;
      stream_q.push_back(sb);
   endfunction

   // Payload content leans towards zeros and ones to build near-start codes
   function automatic logic [BYTE_W-1:0] payload_byte();
      int unsigned roll;
      roll = $urandom_range(99, 0);
      if (roll < 25) return ZERO_BYTE;
      if (roll < 33) return ONE_BYTE;
      if (roll < 36) return 8'h03;
      return BYTE_W'($urandom_range(255, 0));
   endfunction

   task automatic queue_random(int target);
      int start_size;
      int units;
      start_size = stream_q.size();
      while (stream_q.size() - start_size < target) begin
         if ($urandom_range(99, 0) < 15) begin
            // noise: raw bytes, now and then a buffer end
            repeat ($urandom_range(8, 1))
               push_stream(BYTE_W'($urandom_range(255, 0)), $urandom_range(99, 0) < 10);
         end else begin
            // well-formed buffer: optional junk, then units behind start codes
            repeat ($urandom_range(2, 0)) push_stream(BYTE_W'($urandom_range(255, 2)), 1'b0);
            units = $urandom_range(4, 1);
            repeat (units) begin
               if ($urandom_range(1, 0) != 0) push_stream(ZERO_BYTE, 1'b0);
               push_stream(ZERO_BYTE, 1'b0);
               push_stream(ZERO_BYTE, 1'b0);
               push_stream(ONE_BYTE, 1'b0);
               if ($urandom_range(9, 0) != 0) begin
                  push_stream(BYTE_W'($urandom_range(255, 0)), 1'b0);
                  repeat ($urandom_range(12, 0)) push_stream(payload_byte(), 1'b0);
               end
            end
            if ($urandom_range(3, 0) == 0)
               repeat ($urandom_range(3, 1)) push_stream(ZERO_BYTE, 1'b0);
            stream_q[stream_q.size()-1].buf_end = 1'b1;
         end
      end
   endtask

   task automatic wait_quiet();
      while (stream_q.size() != 0 || req_valid || expected_nal_bytes.size() != 0)
         @(negedge clock);
   endtask

   task automatic run_phase(int sender_idle, int receiver_stall, int amount);
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
      queue_random(amount);
      wait_quiet();
   endtask

   // ------------------------------------------------------------------------
   // Driver: offer stream bytes, predict on each accepted transaction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            parse_byte(req_in_byte, req_buffer_end);
            bytes_accepted++;
         end
         // hold a stalled byte, otherwise load the next one or idle
         if (!req_valid || !req_stall) begin
            if (stream_q.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
               drive_byte = stream_q.pop_front();
               req_valid      <= 1'b1;
               req_in_byte    <= drive_byte.data;
               req_buffer_end <= drive_byte.buf_end;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Long output hold-off, counted here
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_request) begin
         hold_left <= HOLD_CYCLES;
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: check each accepted result transaction
   // ------------------------------------------------------------------------
   function automatic void check_field(string field, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_nal_bytes.size() == 0) begin
               $error("unexpected result: out_byte 0x%0h, byte_index %0d",
                      rsp_out_byte, rsp_byte_index);
               failures++;
            end else begin
               want_byte = expected_nal_bytes.pop_front();
               check_field("out_byte",   want_byte.data,      rsp_out_byte);
               check_field("nal_first",  want_byte.first,     rsp_nal_first);
               check_field("nal_last",   want_byte.last,      rsp_nal_last);
               check_field("unit_type",  want_byte.kind,      rsp_unit_type);
               check_field("idr_flag",   want_byte.idr,       rsp_idr_flag);
               check_field("byte_index", want_byte.index,     rsp_byte_index);
               check_field("step_last",  want_byte.step_last, rsp_step_last);
               nal_bytes_checked++;
               if (want_byte.first) units_seen++;
            end
         end
         rsp_stall <= (hold_left != 0) || ($urandom_range(99, 0) < stall_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Sequence of phases
   // ------------------------------------------------------------------------
   initial begin
      clear_parser();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // hand-built opening stream, buffer end on its last byte
      for (int i = 0; i < 25; i++) push_stream(OPENING_BYTES[i], i == 24);
      wait_quiet();

      run_phase(0, 0, PHASE_BYTES);
      run_phase(62, 0, PHASE_BYTES);
      run_phase(0, 62, PHASE_BYTES);
      run_phase(37, 37, PHASE_BYTES);

      // stop the output for a long stretch while bytes keep coming
      idle_pct     = 0;
      stall_pct    = 0;
      hold_request = 1'b1;
      @(negedge clock);
      hold_request = 1'b0;
      queue_random(HOLD_BYTES);
      wait_quiet();

      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Fed %0d stream bytes, checked %0d payload bytes in %0d units.",
               bytes_accepted, nal_bytes_checked, units_seen);
      $display("Covered four idling mixes and a %0d-cycle output hold-off.",
               HOLD_CYCLES);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
